/* hw/rtl/dbd_pkg.sv */
// Shared types, widths, register codes and exp tables for the box decoder.
package dbd_pkg;

  localparam int COORD_FRAC_BITS_DEF = 4;

  localparam int COORD_W   = 16;
  localparam int DELTA_W   = 16;
  localparam int SCORE_W   = 16;
  localparam int IMG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int SIZE_W    = 18;  // box size x2 - x1 + one pixel, signed
  localparam int TOP_W     = 18;  // clamp bound, signed, -(one pixel) .. COORD_MAX
  localparam int NUM_STAGES = 6;

  localparam int COORD_MAX = (1 << COORD_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W-1:0] IMG_SIZE_RST = 13'd1024;

  // 2^(k/16) in Q.16 and the slope to the next entry
  localparam logic [16:0] EXP_BASE [16] = '{
    17'd65536, 17'd68438, 17'd71468, 17'd74632, 17'd77936, 17'd81386,
    17'd84990, 17'd88753, 17'd92682, 17'd96785, 17'd101070, 17'd105545,
    17'd110218, 17'd115098, 17'd120194, 17'd125515
  };
  localparam logic [12:0] EXP_SLOPE [16] = '{
    13'd2902, 13'd3030, 13'd3164, 13'd3304, 13'd3450, 13'd3604,
    13'd3763, 13'd3929, 13'd4103, 13'd4285, 13'd4475, 13'd4673,
    13'd4880, 13'd5096, 13'd5321, 13'd5557
  };

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last_in_roi;
    logic               last_in_set;
  } dbd_side_t;

endpackage

/* hw/rtl/dbd_axis.sv */
// Six-stage decode datapath for one axis: size, exp scale, center shift, clamp.
module dbd_axis import dbd_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [COORD_W-1:0]        a1,
  input  logic [COORD_W-1:0]        a2,
  input  logic signed [DELTA_W-1:0] dc,
  input  logic signed [DELTA_W-1:0] ds,
  input  logic signed [TOP_W-1:0]   top,
  output logic [COORD_W-1:0]        lo,
  output logic [COORD_W-1:0]        hi
);

  localparam int YP_W   = 33;
  localparam int Y_W    = 17;
  localparam int N_W    = 5;
  localparam int M_W    = 17;
  localparam int LERP_W = 21;
  localparam int WD_W   = 34;
  localparam int CTR_W  = 32;
  localparam int EXP_W  = 28;
  localparam int BASE_W = 36;
  localparam int P_W    = 47;
  localparam int EDGE_W = BASE_W - 13;

  localparam logic signed [SIZE_W-1:0] ONE_F     = SIZE_W'(1 << COORD_FRAC_BITS);
  localparam logic signed [16:0]       EXP_SCALE = 17'sd47274;  // log2(e) in Q.15
  localparam logic signed [P_W-1:0]    P_LIM     = P_W'(64'd1 << 33);
  localparam logic signed [BASE_W-1:0] ROUND_HALF = BASE_W'(4096);

  // stage 1
  logic signed [SIZE_W-1:0]  w1_r, w1_nxt;
  logic signed [YP_W-1:0]    yp1_r, yp1_nxt;
  logic [COORD_W-1:0]        p1_1_r;
  logic signed [DELTA_W-1:0] dc1_r;
  // stage 2
  logic signed [Y_W-1:0]     y2;
  logic [3:0]                idx2;
  logic [7:0]                frac2;
  logic [LERP_W-1:0]         lerp2;
  logic [M_W-1:0]            m2_r, m2_nxt;
  logic signed [N_W-1:0]     n2_r, n2_nxt;
  logic signed [WD_W-1:0]    wd2_r, wd2_nxt;
  logic signed [CTR_W-1:0]   ctr2_r, ctr2_nxt;
  logic signed [SIZE_W-1:0]  w2_r;
  // stage 3
  logic [3:0]                nneg3;
  logic [EXP_W-1:0]          exp3_r, exp3_nxt;
  logic signed [BASE_W-1:0]  base3_r, base3_nxt;
  logic signed [SIZE_W-1:0]  w3_r;
  // stage 4
  logic signed [P_W-1:0]     p4_r, p4_nxt;
  logic signed [BASE_W-1:0]  base4_r;
  // stage 5
  logic signed [P_W-1:0]     psat5;
  logic signed [BASE_W-1:0]  half5;
  logic signed [BASE_W-1:0]  lo5_r, lo5_nxt, hi5_r, hi5_nxt;
  // stage 6
  logic [COORD_W-1:0]        lo6_r, lo6_nxt, hi6_r, hi6_nxt;

  function automatic logic [COORD_W-1:0] clamp_edge(input logic signed [EDGE_W-1:0] e,
                                                    input logic signed [TOP_W-1:0] t);
    logic signed [EDGE_W-1:0] v;
    v = e;
    if (v > EDGE_W'(t)) v = EDGE_W'(t);
    if (v < 0) v = '0;
    return COORD_W'(v);
  endfunction

  always_comb begin
    // stage 1: size and exponent argument scaled to log2
    w1_nxt  = $signed({2'b00, a2}) - $signed({2'b00, a1}) + ONE_F;
    yp1_nxt = YP_W'(ds) * YP_W'(EXP_SCALE);

    // stage 2: 2^frac by table plus linear step, center and shift products
    y2     = yp1_r[31:15];
    idx2   = y2[11:8];
    frac2  = y2[7:0];
    lerp2  = LERP_W'(EXP_SLOPE[idx2]) * LERP_W'(frac2);
    m2_nxt = EXP_BASE[idx2] + M_W'(lerp2[LERP_W-1:8]);
    n2_nxt = y2[Y_W-1:12];
    wd2_nxt  = WD_W'(w1_r) * WD_W'(dc1_r);
    ctr2_nxt = $signed({3'b000, p1_1_r, 13'b0}) + (CTR_W'(w1_r) <<< 12);

    // stage 3: integer part of the exponent, center sum
    nneg3 = 4'(-n2_r);
    if (!n2_r[N_W-1]) begin
      exp3_nxt = EXP_W'(m2_r) << n2_r[3:0];
    end else begin
      exp3_nxt = EXP_W'(m2_r) >> nneg3;
    end
    base3_nxt = BASE_W'(ctr2_r) + (BASE_W'(wd2_r) <<< 1) + ROUND_HALF;

    // stage 4: scaled size
    p4_nxt = P_W'(w3_r) * $signed({{(P_W - EXP_W){1'b0}}, exp3_r});

    // stage 5: saturate, halve, both edges
    psat5 = p4_r;
    if (psat5 > P_LIM) psat5 = P_LIM;
    if (psat5 < -P_LIM) psat5 = -P_LIM;
    half5   = BASE_W'(psat5 >>> 4);
    lo5_nxt = base4_r - half5;
    hi5_nxt = base4_r + half5;

    // stage 6: round to coordinate grid and clamp
    lo6_nxt = clamp_edge(lo5_r[BASE_W-1:13], top);
    hi6_nxt = clamp_edge(hi5_r[BASE_W-1:13], top);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r    <= w1_nxt;
      yp1_r   <= yp1_nxt;
      p1_1_r  <= a1;
      dc1_r   <= dc;
      m2_r    <= m2_nxt;
      n2_r    <= n2_nxt;
      wd2_r   <= wd2_nxt;
      ctr2_r  <= ctr2_nxt;
      w2_r    <= w1_r;
      exp3_r  <= exp3_nxt;
      base3_r <= base3_nxt;
      w3_r    <= w2_r;
      p4_r    <= p4_nxt;
      base4_r <= base3_r;
      lo5_r   <= lo5_nxt;
      hi5_r   <= hi5_nxt;
      lo6_r   <= lo6_nxt;
      hi6_r   <= hi6_nxt;
    end
  end

  assign lo = lo6_r;
  assign hi = hi6_r;

endmodule

/* hw/rtl/detection_box_decode_core.sv */
// Detection box decoder top level: proposal plus class deltas in, clamped box out.
//
// Decodes one proposal box and one class's regression deltas into a corner box per
// transaction. Width/height are x2-x1+1 pixel, the center moves by size*delta and
// the size scales by exp(delta) from a 16-entry 2^x table with linear steps; edges
// are rounded to the coordinate grid and clamped to 0..image size minus one pixel.
// Throughput is one transaction per cycle unless out_stall holds the pipe; each
// transaction passes the six-stage datapath per axis (exponent multiply, table step,
// barrel shift, size multiply, edge sums, clamp). out_stall freezes the whole pipeline only
// while a result is waiting at the output, and in_stall then follows out_stall.
// image_width (index 0) and image_height (index 1) are written through the cfg
// channel, which is always ready; write them only while no transaction is in flight.
module detection_box_decode_core import dbd_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [IMG_W-1:0]          cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COORD_W-1:0]        in_roi_x1,
  input  logic [COORD_W-1:0]        in_roi_y1,
  input  logic [COORD_W-1:0]        in_roi_x2,
  input  logic [COORD_W-1:0]        in_roi_y2,
  input  logic signed [DELTA_W-1:0] in_delta_x,
  input  logic signed [DELTA_W-1:0] in_delta_y,
  input  logic signed [DELTA_W-1:0] in_delta_w,
  input  logic signed [DELTA_W-1:0] in_delta_h,
  input  logic [SCORE_W-1:0]        in_class_score,
  input  logic                      in_last_in_roi,
  input  logic                      in_last_in_set,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COORD_W-1:0]        out_box_x1,
  output logic [COORD_W-1:0]        out_box_y1,
  output logic [COORD_W-1:0]        out_box_x2,
  output logic [COORD_W-1:0]        out_box_y2,
  output logic [SCORE_W-1:0]        out_box_score,
  output logic                      out_box_last_in_roi,
  output logic                      out_box_last_in_set
);

  localparam int FULL_W = IMG_W + COORD_FRAC_BITS + 2;

  logic [IMG_W-1:0]          img_w_r, img_w_nxt;
  logic [IMG_W-1:0]          img_h_r, img_h_nxt;
  logic signed [TOP_W-1:0]   top_x, top_y;

  logic                      advance;
  logic [NUM_STAGES-1:0]     vld_r, vld_nxt;
  dbd_side_t                 side_r   [NUM_STAGES];
  dbd_side_t                 side_nxt [NUM_STAGES];

  // Upper clamp in coordinate units: size pixels minus one pixel, capped at the
  // field range. A zero size gives a negative bound, which forces the edge to 0.
  function automatic logic signed [TOP_W-1:0] calc_top(input logic [IMG_W-1:0] img);
    logic signed [FULL_W-1:0] full;
    full = FULL_W'(img) << COORD_FRAC_BITS;
    full = full - FULL_W'(1 << COORD_FRAC_BITS);
    if (full > COORD_MAX) begin
      return TOP_W'(COORD_MAX);
    end
    return TOP_W'(full);
  endfunction

  // ---- configuration registers ----
  assign cfg_ready = 1'b1;

  always_comb begin
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_nxt = cfg_data;
        CFG_IMAGE_HEIGHT: img_h_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_SIZE_RST;
      img_h_r <= IMG_SIZE_RST;
    end else begin
      img_w_r <= img_w_nxt;
      img_h_r <= img_h_nxt;
    end
  end

  assign top_x = calc_top(img_w_r);
  assign top_y = calc_top(img_h_r);

  // ---- pipeline control ----
  // Every stage moves together; the last stage is the output register, so the
  // pipe only holds when a result sits there and the receiver stalls.
  assign advance  = !vld_r[NUM_STAGES-1] || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    vld_nxt     = {vld_r[NUM_STAGES-2:0], in_valid};
    side_nxt[0] = '{score: in_class_score, last_in_roi: in_last_in_roi,
                    last_in_set: in_last_in_set};
    for (int k = 1; k < NUM_STAGES; k++) begin
      side_nxt[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= vld_nxt;
    end
  end

  // sideband travels alongside the datapath, no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      side_r <= side_nxt;
    end
  end

  // ---- datapath, one per axis ----
  dbd_axis #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_axis_x (
    .clk (clk),
    .en  (advance),
    .a1  (in_roi_x1),
    .a2  (in_roi_x2),
    .dc  (in_delta_x),
    .ds  (in_delta_w),
    .top (top_x),
    .lo  (out_box_x1),
    .hi  (out_box_x2)
  );

  dbd_axis #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_axis_y (
    .clk (clk),
    .en  (advance),
    .a1  (in_roi_y1),
    .a2  (in_roi_y2),
    .dc  (in_delta_y),
    .ds  (in_delta_h),
    .top (top_y),
    .lo  (out_box_y1),
    .hi  (out_box_y2)
  );

  assign out_valid           = vld_r[NUM_STAGES-1];
  assign out_box_score       = side_r[NUM_STAGES-1].score;
  assign out_box_last_in_roi = side_r[NUM_STAGES-1].last_in_roi;
  assign out_box_last_in_set = side_r[NUM_STAGES-1].last_in_set;

  // ---- assertions ----
  a_frozen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(vld_r))
    else $error("pipeline valid bits moved while frozen");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transaction did not enter stage one");

  a_reach_output: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STAGES-2] && advance |=> out_valid)
    else $error("transaction lost before the output register");

  a_cfg_width: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_WIDTH |=> img_w_r == $past(cfg_data))
    else $error("image width write not taken");

  a_cfg_height: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_HEIGHT |=> img_h_r == $past(cfg_data))
    else $error("image height write not taken");

endmodule

/* dv/tb_detection_box_decode_core.sv */
// Self-checking testbench for detection_box_decode_core: directed table, then random traffic.
//
// What is checked
//   Each accepted input transaction queues its expected box: the row's own box for typed
//   directed rows, else one from a local predictor (fixed-point Faster R-CNN inverse box
//   transform with a table-based exp). Every transaction accepted on the result channel is
//   compared field by field with the oldest queued box. A result with nothing queued, a
//   wrong field, and a box that never comes out (caught by the cycle limit) fail.
//
// How the stimulus is built
//   1. A short directed table: field extremes, zero/inverted/degenerate boxes, exp
//      saturation in both directions, and the image-size corner cases (zero, one pixel,
//      4096, and 8191 where the clamp bound saturates). Rows whose result is obvious
//      carry the expected box; the rest go through the predictor.
//   2. Random phases, each with its own image size. Most items are well-formed
//      proposals (several classes per proposal, last marks set properly, box starting
//      inside the image, moderate deltas); the rest are raw random items.
//   The image size is only rewritten once the pipeline has drained.
//
// Flow control
//   The sender works in bursts with random gaps. The receiver cycles through stall
//   patterns of its own and, on request, holds off for a long stretch so that the
//   pipeline fills up and the block stalls its input.
module tb_detection_box_decode_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dbd_pkg::*;

  localparam int FRAC            = COORD_FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES    = NUM_STAGES + 4;
  localparam int N_PHASES        = 5;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int LONG_HOLD       = 150;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 60;
  localparam int N_DIR           = 17;

  // 2^(k/16) in Q.16, k = 0..16
  localparam longint EXP2_TAB [17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88753, 92682,
    96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
  };

  typedef struct packed {
    logic [COORD_W-1:0]        roi_x1;
    logic [COORD_W-1:0]        roi_y1;
    logic [COORD_W-1:0]        roi_x2;
    logic [COORD_W-1:0]        roi_y2;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [DELTA_W-1:0] delta_w;
    logic signed [DELTA_W-1:0] delta_h;
    logic [SCORE_W-1:0]        class_score;
    logic                      last_in_roi;
    logic                      last_in_set;
  } box_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] box_x1;
    logic [COORD_W-1:0] box_y1;
    logic [COORD_W-1:0] box_x2;
    logic [COORD_W-1:0] box_y2;
    logic [SCORE_W-1:0] box_score;
    logic               box_last_in_roi;
    logic               box_last_in_set;
  } box_res_t;

  typedef struct {
    box_req_t         req;
    logic [IMG_W-1:0] img_w;
    logic [IMG_W-1:0] img_h;
    bit               typed;   // want holds the expected box
    box_res_t         want;
  } dir_row_t;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic clk;
  logic rst_n;

  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IMG_W-1:0]     cfg_data;

  logic     in_valid;
  logic     in_stall;
  box_req_t in_req;

  logic               out_valid;
  logic               out_stall;
  logic [COORD_W-1:0] out_box_x1;
  logic [COORD_W-1:0] out_box_y1;
  logic [COORD_W-1:0] out_box_x2;
  logic [COORD_W-1:0] out_box_y2;
  logic [SCORE_W-1:0] out_box_score;
  logic               out_box_last_in_roi;
  logic               out_box_last_in_set;

  // local copy of the image size registers
  logic [IMG_W-1:0] img_w_cfg;
  logic [IMG_W-1:0] img_h_cfg;

  box_res_t pending_boxes [$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       burst_left;
  int       hold_requests;

  // Directed table. Image size changes between rows trigger a drain and a rewrite.
  dir_row_t dir_rows [N_DIR] = '{
    // zero box, zero deltas: one-pixel box at the origin
    '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 1'b0, 1'b0}, 13'd1024, 13'd1024, 1'b1,
      '{16'd0, 16'd0, 16'd16, 16'd16, 16'h0000, 1'b0, 1'b0}},
    // full range box, max log scale: size saturates, clamped to the image
    '{'{16'd0, 16'd0, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff,
        16'hffff, 1'b1, 1'b1}, 13'd1024, 13'd1024, 1'b1,
      '{16'd0, 16'd0, 16'd16368, 16'd16368, 16'hffff, 1'b1, 1'b1}},
    // full range box, most negative deltas
    '{'{16'd0, 16'd0, 16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        16'h8000, 1'b1, 1'b0}, 13'd1024, 13'd1024, 1'b0, '0},
    // max center shift
    '{'{16'd160, 16'd800, 16'd320, 16'd1600, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000,
        16'h0001, 1'b0, 1'b1}, 13'd1024, 13'd1024, 1'b0, '0},
    // exp of -1.0 and +1.0, shifts of opposite sign
    '{'{16'd160, 16'd800, 16'd320, 16'd1600, 16'hf000, 16'h1000, 16'hf000, 16'h1000,
        16'h8001, 1'b1, 1'b0}, 13'd1024, 13'd1024, 1'b0, '0},
    // inverted box, used as is
    '{'{16'hffff, 16'd4000, 16'd0, 16'd100, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h7fff, 1'b0, 1'b0}, 13'd1024, 13'd1024, 1'b0, '0},
    // inverted box with max scale: negative size saturates
    '{'{16'hffff, 16'hffff, 16'd0, 16'd0, 16'h4000, 16'hc000, 16'h7fff, 16'h7fff,
        16'h5a5a, 1'b1, 1'b1}, 13'd1024, 13'd1024, 1'b0, '0},
    // degenerate box at the far corner
    '{'{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'ha5a5, 1'b0, 1'b1}, 13'd1024, 13'd1024, 1'b0, '0},
    // mixed fractional deltas
    '{'{16'd3000, 16'd1234, 16'd9000, 16'd7777, 16'h5555, 16'haaaa, 16'h0123, 16'h7ff0,
        16'h0f0f, 1'b0, 1'b0}, 13'd1024, 13'd1024, 1'b0, '0},
    // zero image size: clamp bound is negative, everything lands on 0
    '{'{16'd100, 16'd100, 16'd200, 16'd200, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h1234, 1'b0, 1'b1}, 13'd0, 13'd0, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'h1234, 1'b0, 1'b1}},
    // one-pixel image: clamp bound is 0
    '{'{16'd0, 16'd0, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff,
        16'h00ff, 1'b1, 1'b0}, 13'd1, 13'd1, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'h00ff, 1'b1, 1'b0}},
    // largest register value: bound saturates at the coordinate maximum
    '{'{16'd0, 16'd0, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff,
        16'hff00, 1'b1, 1'b1}, 13'd8191, 13'd8191, 1'b1,
      '{16'd0, 16'd0, 16'hffff, 16'hffff, 16'hff00, 1'b1, 1'b1}},
    '{'{16'd65000, 16'd64000, 16'hffff, 16'hffff, 16'h1000, 16'hf000, 16'h0400, 16'hfc00,
        16'h3c3c, 1'b0, 1'b0}, 13'd8191, 13'd8191, 1'b0, '0},
    '{'{16'd1000, 16'd50, 16'd30000, 16'd900, 16'h0800, 16'h0000, 16'h2000, 16'h0000,
        16'hc3c3, 1'b1, 1'b0}, 13'd4096, 13'd1, 1'b0, '0},
    '{'{16'd0, 16'd0, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hc000, 16'h4000,
        16'h0001, 1'b0, 1'b1}, 13'd8191, 13'd0, 1'b0, '0},
    '{'{16'd65520, 16'd65520, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
        16'hfffe, 1'b1, 1'b1}, 13'd4096, 13'd4096, 1'b0, '0},
    '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        16'h0000, 1'b0, 1'b0}, 13'd1024, 13'd1024, 1'b0, '0}
  };

  detection_box_decode_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_roi_x1           (in_req.roi_x1),
    .in_roi_y1           (in_req.roi_y1),
    .in_roi_x2           (in_req.roi_x2),
    .in_roi_y2           (in_req.roi_y2),
    .in_delta_x          (in_req.delta_x),
    .in_delta_y          (in_req.delta_y),
    .in_delta_w          (in_req.delta_w),
    .in_delta_h          (in_req.delta_h),
    .in_class_score      (in_req.class_score),
    .in_last_in_roi      (in_req.last_in_roi),
    .in_last_in_set      (in_req.last_in_set),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_box_x1          (out_box_x1),
    .out_box_y1          (out_box_y1),
    .out_box_x2          (out_box_x2),
    .out_box_y2          (out_box_y2),
    .out_box_score       (out_box_score),
    .out_box_last_in_roi (out_box_last_in_roi),
    .out_box_last_in_set (out_box_last_in_set)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // exp(d) for d in Q3.12, result in Q.16: d*log2(e) split into integer and
  // fraction, 2^fraction from the table with a linear step, then a shift.
  function automatic longint exp_q16(input logic signed [DELTA_W-1:0] d);
    longint y, n, r, i, j, m;
    y = (longint'(d) * 47274) >>> 15;
    n = y >>> 12;
    r = y - n * 4096;
    i = r >> 8;
    j = r & 255;
    m = EXP2_TAB[i] + (((EXP2_TAB[i+1] - EXP2_TAB[i]) * j) >>> 8);
    if (n >= 0) return m << n;
    return m >>> (-n);
  endfunction

  // One axis: low and high edge, rounded to the coordinate grid and clamped.
  function automatic void decode_axis(input logic [COORD_W-1:0] a1, a2,
                                      input logic signed [DELTA_W-1:0] dc, ds,
                                      input logic [IMG_W-1:0] img,
                                      output logic [COORD_W-1:0] lo_edge, hi_edge);
    longint w, ctr, shift, p, half, lo, hi, top, lim;
    lim   = longint'(1) << 33;
    w     = longint'(a2) - longint'(a1) + (longint'(1) << FRAC);
    // edge terms carry 13 more fraction bits than the coordinates
    ctr   = longint'(a1) * 8192 + w * 4096;
    shift = 2 * w * longint'(dc);
    p     = w * exp_q16(ds);
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    half  = p >>> 4;
    lo    = (ctr + shift - half + 4096) >>> 13;
    hi    = (ctr + shift + half + 4096) >>> 13;
    top   = (longint'(img) << FRAC) - (longint'(1) << FRAC);
    if (top > COORD_MAX) top = COORD_MAX;
    // upper bound first, then zero
    if (lo > top) lo = top;
    if (lo < 0) lo = 0;
    if (hi > top) hi = top;
    if (hi < 0) hi = 0;
    lo_edge = lo[COORD_W-1:0];
    hi_edge = hi[COORD_W-1:0];
  endfunction

  function automatic box_res_t decode_box(input box_req_t req);
    box_res_t res;
    decode_axis(req.roi_x1, req.roi_x2, req.delta_x, req.delta_w, img_w_cfg,
                res.box_x1, res.box_x2);
    decode_axis(req.roi_y1, req.roi_y2, req.delta_y, req.delta_h, img_h_cfg,
                res.box_y1, res.box_y2);
    res.box_score       = req.class_score;
    res.box_last_in_roi = req.last_in_roi;
    res.box_last_in_set = req.last_in_set;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Bursts of back-to-back transactions separated by short random gaps.
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    return $urandom_range(1, 6);
  endfunction

  // Called just after the clock rises; returns as soon as the item has been accepted.
  task automatic send_box(input box_req_t req, input int gap, input bit typed,
                          input box_res_t want);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    pending_boxes.insert(pending_boxes.size(), typed ? want : decode_box(req));
  endtask

  // Drain: every queued box out, then a further wait for the pipeline to empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both size registers, back to back; only called while the block is idle.
  task automatic set_image(input logic [IMG_W-1:0] w, h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    img_w_cfg = w;
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    img_h_cfg = h;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall patterns, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rx_pattern
    rx_mode_t mode;
    int       left;
    int       hold_left;
    int       holds_seen;
    out_stall <= 1'b0;
    mode       = RX_FLOW;
    left       = 0;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(10, 120);
        end
        left--;
        case (mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= left[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [15:0] want_v, got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin : result_check
    box_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_boxes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: result transaction with no expectation, x1=%0d y1=%0d",
                   $time, out_box_x1, out_box_y1);
      end else begin
        want = pending_boxes.pop_front();
        if (out_box_x1 !== want.box_x1) report_mismatch("box_x1", want.box_x1, out_box_x1);
        if (out_box_y1 !== want.box_y1) report_mismatch("box_y1", want.box_y1, out_box_y1);
        if (out_box_x2 !== want.box_x2) report_mismatch("box_x2", want.box_x2, out_box_x2);
        if (out_box_y2 !== want.box_y2) report_mismatch("box_y2", want.box_y2, out_box_y2);
        if (out_box_score !== want.box_score)
          report_mismatch("box_score", want.box_score, out_box_score);
        if (out_box_last_in_roi !== want.box_last_in_roi)
          report_mismatch("box_last_in_roi", want.box_last_in_roi, out_box_last_in_roi);
        if (out_box_last_in_set !== want.box_last_in_set)
          report_mismatch("box_last_in_set", want.box_last_in_set, out_box_last_in_set);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d boxes still pending", $time, pending_boxes.size());
      $display("detection_box_decode_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    box_req_t         req;
    box_req_t         roi;
    box_res_t         no_want;
    int               classes_left;
    int               span_x;
    int               span_y;
    logic [IMG_W-1:0] ph_w;
    logic [IMG_W-1:0] ph_h;

    no_want       = '0;
    burst_left    = 0;
    img_w_cfg     = IMG_SIZE_RST;
    img_h_cfg     = IMG_SIZE_RST;
    roi           = '0;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_IMAGE_WIDTH;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_req        <= '0;
    hold_requests <= 0;

    // synchronous reset, then release
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, at the reset image size until a row asks for another
    foreach (dir_rows[k]) begin
      if (dir_rows[k].img_w != img_w_cfg || dir_rows[k].img_h != img_h_cfg) begin
        wait_idle();
        set_image(dir_rows[k].img_w, dir_rows[k].img_h);
      end
      send_box(dir_rows[k].req, next_gap(), dir_rows[k].typed, dir_rows[k].want);
    end

    // random phases, one image size each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       begin ph_w = 13'd4096; ph_h = 13'd4096; end
        1:       begin ph_w = 13'd1;    ph_h = 13'd8191; end
        2:       begin ph_w = 13'd640;  ph_h = 13'd480;  end
        default: begin
          ph_w = IMG_W'($urandom_range(1, 4096));
          ph_h = IMG_W'($urandom_range(1, 4096));
        end
      endcase
      set_image(ph_w, ph_h);
      // long receiver hold-off while the sender keeps pushing
      if (ph == 0 || ph == 3) hold_requests <= hold_requests + 1;

      span_x = (ph_w == 0) ? 16 : ((int'(ph_w) * 16 > 65536) ? 65536 : int'(ph_w) * 16);
      span_y = (ph_h == 0) ? 16 : ((int'(ph_h) * 16 > 65536) ? 65536 : int'(ph_h) * 16);
      classes_left = 0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          // noise: every field raw random
          req.roi_x1      = 16'($urandom());
          req.roi_y1      = 16'($urandom());
          req.roi_x2      = 16'($urandom());
          req.roi_y2      = 16'($urandom());
          req.delta_x     = 16'($urandom());
          req.delta_y     = 16'($urandom());
          req.delta_w     = 16'($urandom());
          req.delta_h     = 16'($urandom());
          req.class_score = 16'($urandom());
          req.last_in_roi = 1'($urandom());
          req.last_in_set = 1'($urandom());
        end else begin
          // proposal starting inside the image, several classes per proposal
          if (classes_left == 0) begin
            roi.roi_x1   = 16'($urandom_range(0, span_x - 1));
            roi.roi_y1   = 16'($urandom_range(0, span_y - 1));
            roi.roi_x2   = 16'((int'(roi.roi_x1) + int'($urandom_range(0, span_x / 2)) > 65535)
                               ? 65535 : int'(roi.roi_x1) + int'($urandom_range(0, span_x / 2)));
            roi.roi_y2   = 16'((int'(roi.roi_y1) + int'($urandom_range(0, span_y / 2)) > 65535)
                               ? 65535 : int'(roi.roi_y1) + int'($urandom_range(0, span_y / 2)));
            classes_left = $urandom_range(1, 4);
          end
          req = roi;
          // mostly within +-2.0, now and then the full range
          req.delta_x = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                        : 16'(int'($urandom_range(0, 16383)) - 8192);
          req.delta_y = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                        : 16'(int'($urandom_range(0, 16383)) - 8192);
          req.delta_w = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                        : 16'(int'($urandom_range(0, 16383)) - 8192);
          req.delta_h = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                        : 16'(int'($urandom_range(0, 16383)) - 8192);
          req.class_score = 16'($urandom());
          classes_left--;
          req.last_in_roi = (classes_left == 0);
          req.last_in_set = (n == ITEMS_PER_PHASE - 1);
        end
        send_box(req, next_gap(), 1'b0, no_want);
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_boxes.size() == 0) begin
      $display("detection_box_decode_core test passed");
    end else begin
      $display("detection_box_decode_core test failed");
    end
    $finish;
  end

endmodule
